>>> hdl/mvcc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvcc_pkg
// Shared sizes, constants and operation codes of the row version table.
// ---------------------------------------------------------------------------
package mvcc_pkg;

  localparam int ROWS     = 1024;
  localparam int ROW_BITS = $clog2(ROWS);
  localparam int CNT_BITS = ROW_BITS + 1;
  localparam int ID_BITS  = 32;
  localparam int OP_BITS  = 4;
  localparam int ST_BITS  = 2;
  localparam int ENTRY_BITS = 3 * ID_BITS;

  localparam logic [ID_BITS-1:0] INF_CID  = '1;
  localparam logic [ID_BITS-1:0] FREE_TID = ID_BITS'(1);

  localparam logic [OP_BITS-1:0] OP_QUERY         = OP_BITS'(0);
  localparam logic [OP_BITS-1:0] OP_COMMIT_INSERT = OP_BITS'(1);
  localparam logic [OP_BITS-1:0] OP_COMMIT_DELETE = OP_BITS'(2);
  localparam logic [OP_BITS-1:0] OP_REVERT_INSERT = OP_BITS'(3);
  localparam logic [OP_BITS-1:0] OP_REVERT_DELETE = OP_BITS'(4);
  localparam logic [OP_BITS-1:0] OP_CHECK         = OP_BITS'(5);
  localparam logic [OP_BITS-1:0] OP_MARK          = OP_BITS'(6);
  localparam logic [OP_BITS-1:0] OP_UNMARK        = OP_BITS'(7);
  localparam logic [OP_BITS-1:0] OP_APPEND        = OP_BITS'(8);
  localparam logic [OP_BITS-1:0] OP_CLAIM         = OP_BITS'(9);

  localparam logic [ST_BITS-1:0] ST_OK       = ST_BITS'(0);
  localparam logic [ST_BITS-1:0] ST_CONFLICT = ST_BITS'(1);
  localparam logic [ST_BITS-1:0] ST_RANGE    = ST_BITS'(2);

  typedef struct packed {
    logic [ID_BITS-1:0] begin_cid;
    logic [ID_BITS-1:0] end_cid;
    logic [ID_BITS-1:0] owner_tid;
  } row_entry_t;

endpackage

>>> hdl/mvcc_row_version_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvcc_row_version_table
// Multiversion row table: visibility query, commit, revert, check, mark,
// unmark, claim and append over rows kept in one registered-read RAM.
// ---------------------------------------------------------------------------
// An accepted item is registered with its RAM read; its result is registered
//   from S_EXEC (RAM read, then modify and write back) once the output register
//   is free. The input stalls until the item is through: a held result stalls
//   it until it leaves, and an append stalls it while its rows are written, one row written a cycle.
// Reset clears the row count, the sticky check failure and the control state;
//   row contents are not cleared, rows become defined as they are appended.
// ---------------------------------------------------------------------------
module mvcc_row_version_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mvcc_pkg::OP_BITS-1:0]  in_operation,
  input  logic [mvcc_pkg::ROW_BITS-1:0] in_position,
  input  logic [mvcc_pkg::ID_BITS-1:0]  in_commit_id,
  input  logic [mvcc_pkg::ID_BITS-1:0]  in_txn_id,
  input  logic [mvcc_pkg::CNT_BITS-1:0] in_append_count,
  input  logic                          in_list_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mvcc_pkg::ST_BITS-1:0]  out_status,
  output logic                          out_visible,
  output logic [mvcc_pkg::CNT_BITS-1:0] out_first_row,
  output logic [mvcc_pkg::CNT_BITS-1:0] out_end_row
);
  import mvcc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FILL} state_t;

  state_t              state_r;
  logic [OP_BITS-1:0]  op_r;
  logic [ROW_BITS-1:0] pos_r;
  logic [ID_BITS-1:0]  cid_r;
  logic [ID_BITS-1:0]  tid_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                last_r;
  logic [CNT_BITS-1:0] row_count_r;
  logic [CNT_BITS-1:0] row_count_nxt;
  logic                check_failed_r;
  logic                check_failed_nxt;
  logic [CNT_BITS-1:0] fill_ptr_r;

  logic                out_valid_r;
  logic [ST_BITS-1:0]  status_r;
  logic                visible_r;
  logic [CNT_BITS-1:0] first_row_r;
  logic [CNT_BITS-1:0] end_row_r;

  logic [ST_BITS-1:0]  status_nxt;
  logic                visible_nxt;
  logic [CNT_BITS-1:0] first_row_nxt;
  logic [CNT_BITS-1:0] end_row_nxt;

  logic                in_acc;
  logic                emit_ok;
  logic                emit;
  logic                in_range;
  logic [CNT_BITS:0]   append_sum;
  logic                append_ok;
  logic                fail;

  row_entry_t          rd_entry;
  row_entry_t          mod_entry;
  row_entry_t          fill_entry;
  logic                mod_wr;
  logic                mem_wr_en;
  logic [ROW_BITS-1:0] mem_wr_addr;
  row_entry_t          mem_wr_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign emit_ok   = !out_valid_r || !out_stall;
  assign emit      = (state_r == S_EXEC) && emit_ok;

  assign in_range   = {1'b0, pos_r} < row_count_r;
  assign append_sum = {1'b0, row_count_r} + {1'b0, cnt_r};
  assign append_ok  = append_sum <= (CNT_BITS + 1)'(ROWS);

  assign fill_entry = '{begin_cid: INF_CID, end_cid: INF_CID, owner_tid: FREE_TID};

  always_comb begin
    status_nxt       = ST_OK;
    visible_nxt      = 1'b0;
    first_row_nxt    = '0;
    end_row_nxt      = '0;
    row_count_nxt    = row_count_r;
    check_failed_nxt = check_failed_r;
    mod_entry        = rd_entry;
    mod_wr           = 1'b0;
    fail             = 1'b0;

    if (op_r == OP_APPEND) begin
      if (append_ok) begin
        first_row_nxt = row_count_r;
        row_count_nxt = append_sum[CNT_BITS-1:0];
        end_row_nxt   = append_sum[CNT_BITS-1:0];
      end else begin
        status_nxt = ST_RANGE;
      end
    end else if (op_r == OP_CHECK) begin
      if (!in_range) begin
        status_nxt = ST_RANGE;
        fail       = 1'b1;
      end else begin
        fail = check_failed_r || (rd_entry.owner_tid != tid_r) ||
               (rd_entry.end_cid != INF_CID);
        status_nxt = fail ? ST_CONFLICT : ST_OK;
      end
      check_failed_nxt = last_r ? 1'b0 : fail;
    end else if (op_r <= OP_CLAIM) begin
      if (!in_range) begin
        status_nxt = ST_RANGE;
      end else begin
        case (op_r)
          OP_QUERY: begin
            visible_nxt = (cid_r < rd_entry.end_cid) &&
                          ((cid_r >= rd_entry.begin_cid) || (rd_entry.owner_tid == tid_r));
          end
          OP_COMMIT_INSERT: begin
            mod_entry.begin_cid = cid_r;
            mod_entry.owner_tid = FREE_TID;
            mod_wr = 1'b1;
          end
          OP_COMMIT_DELETE: begin
            mod_entry.end_cid = cid_r;
            mod_wr = 1'b1;
          end
          OP_REVERT_INSERT: begin
            mod_entry.begin_cid = INF_CID;
            mod_wr = 1'b1;
          end
          OP_REVERT_DELETE: begin
            mod_entry.end_cid = INF_CID;
            mod_wr = 1'b1;
          end
          OP_MARK: begin
            if (rd_entry.owner_tid == FREE_TID) begin
              mod_entry.owner_tid = tid_r;
              mod_wr = 1'b1;
            end else if (!(rd_entry.owner_tid == tid_r && rd_entry.end_cid == INF_CID)) begin
              status_nxt = ST_CONFLICT;
            end
          end
          OP_UNMARK: begin
            if (rd_entry.owner_tid == tid_r) begin
              mod_entry.owner_tid = FREE_TID;
              mod_wr = 1'b1;
            end
          end
          OP_CLAIM: begin
            mod_entry.owner_tid = tid_r;
            mod_wr = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // fill walk owns the write port; otherwise write back on emit
  always_comb begin
    if (state_r == S_FILL) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = fill_ptr_r[ROW_BITS-1:0];
      mem_wr_data = fill_entry;
    end else begin
      mem_wr_en   = emit && mod_wr;
      mem_wr_addr = pos_r;
      mem_wr_data = mod_entry;
    end
  end

  mvcc_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (ROWS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_position),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      row_count_r    <= '0;
      check_failed_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !emit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= in_operation;
            pos_r   <= in_position;
            cid_r   <= in_commit_id;
            tid_r   <= in_txn_id;
            cnt_r   <= in_append_count;
            last_r  <= in_list_last;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          // hold until the output register is free
          if (emit_ok) begin
            out_valid_r    <= 1'b1;
            status_r       <= status_nxt;
            visible_r      <= visible_nxt;
            first_row_r    <= first_row_nxt;
            end_row_r      <= end_row_nxt;
            row_count_r    <= row_count_nxt;
            check_failed_r <= check_failed_nxt;
            fill_ptr_r     <= row_count_r;
            if (op_r == OP_APPEND && append_ok && cnt_r != '0) begin
              state_r <= S_FILL;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_FILL: begin
          fill_ptr_r <= fill_ptr_r + CNT_BITS'(1);
          if (fill_ptr_r + CNT_BITS'(1) == row_count_r) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_visible   = visible_r;
  assign out_first_row = first_row_r;
  assign out_end_row   = end_row_r;

endmodule

>>> hdl/mvcc_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvcc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mvcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> test/tb_mvcc_row_version_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_mvcc_row_version_table
// Self-checking bench for the row version table. A scoreboard class keeps
// its own copy of the rows, the row count and the sticky check failure, and
// predicts the result of every accepted item. Stimulus is a directed opening,
// then insert and delete transactions, queries, appends and noise, with
// random gaps on the input and random stalls on the result side.
// ---------------------------------------------------------------------------
module tb_mvcc_row_version_table;
  import mvcc_pkg::*;

  localparam int ITEM_GOAL   = 1450;
  localparam int FILL_AT     = 1150;
  localparam int DRAIN_EVERY = 300;

  typedef struct {
    logic [OP_BITS-1:0]  operation;
    logic [ROW_BITS-1:0] position;
    logic [ID_BITS-1:0]  commit_id;
    logic [ID_BITS-1:0]  txn_id;
    logic [CNT_BITS-1:0] append_count;
    logic                list_last;
  } table_item_t;

  typedef struct {
    logic [ST_BITS-1:0]  status;
    logic                visible;
    logic [CNT_BITS-1:0] first_row;
    logic [CNT_BITS-1:0] end_row;
  } table_result_t;

  class version_table_book;
    logic [ID_BITS-1:0] begin_ids [ROWS];
    logic [ID_BITS-1:0] end_ids   [ROWS];
    logic [ID_BITS-1:0] owner_ids [ROWS];
    int                 row_total;
    logic               check_sticky;
    table_result_t      awaited_results [$];
    int                 faults;

    function new();
      row_total    = 0;
      check_sticky = 1'b0;
      faults       = 0;
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    function void note_item(table_item_t it);
      table_result_t r;
      logic          fail;
      bit            live;
      int            p;
      int            i;
      r.status    = ST_OK;
      r.visible   = 1'b0;
      r.first_row = '0;
      r.end_row   = '0;
      p    = int'(it.position);
      live = p < row_total;
      if (it.operation == OP_APPEND) begin
        if (row_total + int'(it.append_count) > ROWS) begin
          r.status = ST_RANGE;
        end else begin
          for (i = row_total; i < row_total + int'(it.append_count); i++) begin
            begin_ids[i] = INF_CID;
            end_ids[i]   = INF_CID;
            owner_ids[i] = FREE_TID;
          end
          r.first_row = CNT_BITS'(row_total);
          row_total  += int'(it.append_count);
          r.end_row   = CNT_BITS'(row_total);
        end
      end else if (it.operation == OP_CHECK) begin
        if (!live) begin
          r.status = ST_RANGE;
          fail     = 1'b1;
        end else begin
          fail = check_sticky || owner_ids[p] != it.txn_id || end_ids[p] != INF_CID;
          r.status = fail ? ST_CONFLICT : ST_OK;
        end
        // a list end clears the sticky failure whatever this item did
        check_sticky = it.list_last ? 1'b0 : fail;
      end else if (it.operation <= OP_CLAIM) begin
        if (!live) begin
          r.status = ST_RANGE;
        end else begin
          case (it.operation)
            OP_QUERY: begin
              r.visible = it.commit_id < end_ids[p] &&
                          (it.commit_id >= begin_ids[p] || owner_ids[p] == it.txn_id);
            end
            OP_COMMIT_INSERT: begin
              begin_ids[p] = it.commit_id;
              owner_ids[p] = FREE_TID;
            end
            OP_COMMIT_DELETE: end_ids[p] = it.commit_id;
            OP_REVERT_INSERT: begin_ids[p] = INF_CID;
            OP_REVERT_DELETE: end_ids[p] = INF_CID;
            OP_MARK: begin
              if (owner_ids[p] == FREE_TID) begin
                owner_ids[p] = it.txn_id;
              end else if (!(owner_ids[p] == it.txn_id && end_ids[p] == INF_CID)) begin
                r.status = ST_CONFLICT;
              end
            end
            OP_UNMARK: begin
              if (owner_ids[p] == it.txn_id) owner_ids[p] = FREE_TID;
            end
            OP_CLAIM: owner_ids[p] = it.txn_id;
            default: ;
          endcase
        end
      end
      awaited_results = {awaited_results, r};
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (awaited_results.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: result with nothing outstanding: status %0d vis %0b first %0d end %0d",
                   $time, got.status, got.visible, got.first_row, got.end_row);
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.visible !== want.visible ||
          got.first_row !== want.first_row || got.end_row !== want.end_row) begin
        faults++;
        if (faults <= 10)
          $display("%0t: want status %0d vis %0b first %0d end %0d, got status %0d vis %0b first %0d end %0d",
                   $time, want.status, want.visible, want.first_row, want.end_row,
                   got.status, got.visible, got.first_row, got.end_row);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OP_BITS-1:0]  in_operation;
  logic [ROW_BITS-1:0] in_position;
  logic [ID_BITS-1:0]  in_commit_id;
  logic [ID_BITS-1:0]  in_txn_id;
  logic [CNT_BITS-1:0] in_append_count;
  logic                in_list_last;
  logic                out_valid;
  logic                out_stall;
  logic [ST_BITS-1:0]  out_status;
  logic                out_visible;
  logic [CNT_BITS-1:0] out_first_row;
  logic [CNT_BITS-1:0] out_end_row;

  version_table_book   book;
  int                  sent_items;
  int                  calm_left;
  logic [ID_BITS-1:0]  next_txn;
  logic [ID_BITS-1:0]  commit_clock;

  mvcc_row_version_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_commit_id    (in_commit_id),
    .in_txn_id       (in_txn_id),
    .in_append_count (in_append_count),
    .in_list_last    (in_list_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_visible     (out_visible),
    .out_first_row   (out_first_row),
    .out_end_row     (out_end_row)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: bursts of stall, some long, with stall-free stretches
  initial begin
    int hold_left;
    int free_left;
    int r;
    out_stall = 1'b0;
    hold_left = 0;
    free_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && free_left == 0) begin
        r = $urandom_range(99);
        if (r < 8) begin
          free_left = $urandom_range(40, 150);
        end else if (r < 14) begin
          hold_left = $urandom_range(8, 30);
          free_left = $urandom_range(1, 4);
        end else begin
          hold_left = $urandom_range(0, 3);
          free_left = $urandom_range(1, 8);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
        free_left--;
      end
    end
  end

  initial begin
    table_result_t seen;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        seen.status    = out_status;
        seen.visible   = out_visible;
        seen.first_row = out_first_row;
        seen.end_row   = out_end_row;
        book.check_result(seen);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 5) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input table_item_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_operation    <= it.operation;
    in_position     <= it.position;
    in_commit_id    <= it.commit_id;
    in_txn_id       <= it.txn_id;
    in_append_count <= it.append_count;
    in_list_last    <= it.list_last;
    do @(posedge clk); while (in_stall);
    book.note_item(it);
    sent_items++;
  endtask

  task automatic issue(input logic [OP_BITS-1:0] op, input int pos,
                       input logic [ID_BITS-1:0] cid, input logic [ID_BITS-1:0] tid,
                       input int cnt, input bit last);
    table_item_t it;
    it.operation    = op;
    it.position     = ROW_BITS'(pos);
    it.commit_id    = cid;
    it.txn_id       = tid;
    it.append_count = CNT_BITS'(cnt);
    it.list_last    = last;
    send_item(it);
  endtask

  // hold the input idle until every outstanding result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
  endtask

  function automatic int pick_row();
    if (book.row_total == 0 || $urandom_range(99) < 15) return $urandom_range(ROWS - 1);
    return $urandom_range(book.row_total - 1);
  endfunction

  function automatic int pick_live_row();
    if (book.row_total == 0) return $urandom_range(ROWS - 1);
    return $urandom_range(book.row_total - 1);
  endfunction

  function automatic logic [ID_BITS-1:0] pick_cid();
    case ($urandom_range(9))
      0:       return INF_CID;
      1:       return '0;
      2:       return $urandom;
      default: return commit_clock + $urandom_range(0, 12) - 6;
    endcase
  endfunction

  function automatic logic [ID_BITS-1:0] pick_tid();
    case ($urandom_range(9))
      0:       return FREE_TID;
      1:       return '0;
      2:       return '1;
      3:       return $urandom;
      default: return next_txn - $urandom_range(0, 8);
    endcase
  endfunction

  function automatic logic [ID_BITS-1:0] fresh_txn();
    next_txn = next_txn + 1;
    return next_txn;
  endfunction

  function automatic logic [ID_BITS-1:0] tick_commit();
    commit_clock = commit_clock + $urandom_range(1, 5);
    return commit_clock;
  endfunction

  task automatic run_directed();
    issue(OP_QUERY,  0, 32'd0, FREE_TID, 0, 1'b0);    // empty table
    issue(OP_CHECK,  0, 32'd0, FREE_TID, 0, 1'b0);    // out of range sets the sticky failure
    issue(OP_APPEND, 0, 32'd0, 32'd0, 0, 1'b0);       // zero count
    issue(OP_APPEND, 0, 32'd0, 32'd0, 2047, 1'b1);    // count above the table size
    issue(OP_APPEND, 0, 32'd0, 32'd0, ROWS + 1, 1'b0);
    issue(OP_APPEND, 0, 32'd0, 32'd0, 4, 1'b0);
    issue(OP_QUERY,  1, 32'd0, 32'd0, 0, 1'b0);
    issue(OP_QUERY,  1, INF_CID, FREE_TID, 0, 1'b0);
    issue(OP_CLAIM,  1, 32'd0, 32'd7, 0, 1'b0);
    issue(OP_QUERY,  1, 32'd5, 32'd7, 0, 1'b0);       // visible to its owner
    issue(OP_CHECK,  1, 32'd0, 32'd7, 0, 1'b1);       // fails on the sticky bit, then clears
    issue(OP_CHECK,  1, 32'd0, 32'd7, 0, 1'b1);
    issue(OP_COMMIT_INSERT, 1, 32'd10, 32'd7, 0, 1'b0);
    issue(OP_QUERY,  1, 32'd10, 32'd0, 0, 1'b0);
    issue(OP_QUERY,  1, 32'd9, 32'd0, 0, 1'b0);
    issue(OP_MARK,   1, 32'd0, 32'd8, 0, 1'b0);       // free row is claimed
    issue(OP_MARK,   1, 32'd0, 32'd9, 0, 1'b0);       // owned by another
    issue(OP_MARK,   1, 32'd0, 32'd8, 0, 1'b0);       // kept by its owner
    issue(OP_COMMIT_DELETE, 1, 32'd20, 32'd8, 0, 1'b0);
    issue(OP_MARK,   1, 32'd0, 32'd8, 0, 1'b0);       // owner, but already deleted
    issue(OP_REVERT_DELETE, 1, 32'd0, 32'd8, 0, 1'b0);
    issue(OP_UNMARK, 1, 32'd0, 32'd9, 0, 1'b0);       // not the owner: no change
    issue(OP_UNMARK, 1, 32'd0, 32'd8, 0, 1'b0);
    issue(OP_REVERT_INSERT, 2, 32'd0, 32'd0, 0, 1'b0);
    issue(OP_CLAIM,  3, '1, '1, 0, 1'b0);
    issue(OP_CHECK,  3, '1, '1, 0, 1'b1);
    issue(OP_QUERY, ROWS - 1, '1, '1, 0, 1'b1);
    issue(OP_BITS'(OP_APPEND + 2), 5, $urandom, $urandom, 3, 1'b1);  // unused opcode
    issue('1, 1, $urandom, $urandom, 2047, 1'b0);
  endtask

  task automatic run_insert_txn();
    logic [ID_BITS-1:0] tid;
    int                 rows [$];
    int                 n;
    int                 base;
    int                 k;
    tid = fresh_txn();
    n   = $urandom_range(1, 3);
    if (book.row_total + n <= ROWS && $urandom_range(3) != 0) begin
      base = book.row_total;
      issue(OP_APPEND, $urandom_range(ROWS - 1), $urandom, $urandom, n, $urandom_range(1));
      for (k = 0; k < n; k++) rows = {rows, base + k};
    end else begin
      for (k = 0; k < n; k++) rows = {rows, pick_live_row()};
    end
    foreach (rows[i])
      issue(OP_CLAIM, rows[i], $urandom, tid, $urandom_range(2047), $urandom_range(1));
    if ($urandom_range(1))
      issue(OP_QUERY, rows[0], pick_cid(), $urandom_range(3) == 0 ? pick_tid() : tid,
            $urandom_range(2047), $urandom_range(1));
    foreach (rows[i])
      issue(OP_CHECK, rows[i], $urandom, $urandom_range(9) == 0 ? pick_tid() : tid,
            $urandom_range(2047), i == rows.size() - 1);
    if ($urandom_range(3) == 0) begin
      foreach (rows[i])
        issue(OP_REVERT_INSERT, rows[i], $urandom, tid, $urandom_range(2047), $urandom_range(1));
    end else begin
      foreach (rows[i])
        issue(OP_COMMIT_INSERT, rows[i], tick_commit(), tid, $urandom_range(2047),
              $urandom_range(1));
    end
  endtask

  task automatic run_delete_txn();
    logic [ID_BITS-1:0] tid;
    int                 rows [$];
    int                 n;
    int                 k;
    tid = fresh_txn();
    n   = $urandom_range(1, 4);
    for (k = 0; k < n; k++) rows = {rows, pick_live_row()};
    // an earlier writer sometimes grabs the first row
    if ($urandom_range(4) == 0)
      issue(OP_MARK, rows[0], $urandom, pick_tid(), $urandom_range(2047), $urandom_range(1));
    foreach (rows[i])
      issue(OP_MARK, rows[i], $urandom, tid, $urandom_range(2047), $urandom_range(1));
    foreach (rows[i])
      issue(OP_CHECK, rows[i], $urandom, $urandom_range(9) == 0 ? pick_tid() : tid,
            $urandom_range(2047), i == rows.size() - 1);
    if ($urandom_range(9) < 3) begin
      foreach (rows[i]) begin
        issue(OP_REVERT_DELETE, rows[i], $urandom, tid, $urandom_range(2047), $urandom_range(1));
        issue(OP_UNMARK, rows[i], $urandom, tid, $urandom_range(2047), $urandom_range(1));
      end
    end else begin
      foreach (rows[i])
        issue(OP_COMMIT_DELETE, rows[i], tick_commit(), tid, $urandom_range(2047),
              $urandom_range(1));
    end
    if ($urandom_range(1))
      issue(OP_QUERY, rows[0], pick_cid(), pick_tid(), $urandom_range(2047), $urandom_range(1));
  endtask

  task automatic run_queries();
    int n;
    n = $urandom_range(1, 5);
    repeat (n)
      issue(OP_QUERY, pick_row(), pick_cid(), pick_tid(), $urandom_range(2047), $urandom_range(1));
  endtask

  task automatic random_append();
    int r;
    int cnt;
    r = $urandom_range(99);
    if (r < 80) cnt = $urandom_range(1, 8);
    else if (r < 92) cnt = $urandom_range(16, 96);
    else if (r < 96) cnt = 0;
    else cnt = $urandom_range(ROWS + 1, 2047);
    issue(OP_APPEND, $urandom_range(ROWS - 1), $urandom, $urandom, cnt, $urandom_range(1));
  endtask

  task automatic random_single();
    logic [OP_BITS-1:0] op;
    op = OP_BITS'($urandom_range(OP_CLAIM));
    if (op == OP_APPEND) random_append();
    else issue(op, pick_row(), pick_cid(), pick_tid(), $urandom_range(2047), $urandom_range(1));
  endtask

  task automatic random_noise();
    logic [OP_BITS-1:0] op;
    int                 cnt;
    op  = OP_BITS'($urandom_range(15));
    cnt = $urandom_range(2047);
    // keep random appends from filling the table early
    if (op == OP_APPEND && cnt <= ROWS - book.row_total) cnt = cnt % 8;
    issue(op, $urandom_range(ROWS - 1), $urandom, $urandom, cnt, $urandom_range(1));
  endtask

  task automatic fill_table();
    if (book.row_total < ROWS)
      issue(OP_APPEND, $urandom_range(ROWS - 1), $urandom, $urandom, ROWS - book.row_total, 1'b0);
    issue(OP_APPEND, $urandom_range(ROWS - 1), $urandom, $urandom, 1, 1'b1);
  endtask

  initial begin
    int  pick;
    int  next_drain;
    bit  filled;
    book            = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_QUERY;
    in_position     = '0;
    in_commit_id    = '0;
    in_txn_id       = '0;
    in_append_count = '0;
    in_list_last    = 1'b0;
    sent_items      = 0;
    calm_left       = 0;
    next_txn        = 32'd100;
    commit_clock    = 32'd1000;
    next_drain      = DRAIN_EVERY;
    filled          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain_results();

    while (sent_items < ITEM_GOAL) begin
      if (sent_items >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
      if (!filled && sent_items >= FILL_AT) begin
        fill_table();
        filled = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 15) run_insert_txn();
      else if (pick < 35) run_delete_txn();
      else if (pick < 60) run_queries();
      else if (pick < 70) random_append();
      else if (pick < 95) random_single();
      else random_noise();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (book.faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
